@@ src/triangle_normal_degenerate_filter_unit_defines.svh @@
// Assertion macros shared by the triangle normal unit.
`ifndef TRIANGLE_NORMAL_DEGENERATE_FILTER_UNIT_DEFINES_SVH
`define TRIANGLE_NORMAL_DEGENERATE_FILTER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Condition must hold at every edge.
`define TNDF_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define TNDF_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define TNDF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TNDF_ASSERT(lbl, clk, rst_n, cond, msg)
`define TNDF_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`define TNDF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

@@ src/tndf_pkg.sv @@
// Shared widths, constants and stage types of the triangle normal unit.
`timescale 1ns / 1ps
package tndf_pkg;

  localparam int COORD_BITS  = 24;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int MAG_W       = PROD_W - 1;
  localparam int SAT_BITS    = 45;
  localparam int SPLIT_LO    = 23;
  localparam int SPLIT_HI    = SAT_BITS - SPLIT_LO;
  localparam int SQ_FULL_W   = 2 * SAT_BITS;
  localparam int ACC_W       = SQ_FULL_W + 2;
  localparam int AREA_SHIFT  = 26;
  localparam int AREA_W      = 64;
  localparam int S_W         = 31;
  localparam int SQ_W        = 2 * S_W;
  localparam int SUM_W       = 64;
  localparam int K_W         = $clog2(MAG_W);
  localparam int OUT_W       = 16;
  localparam int OUT_MAX     = 2 ** (OUT_W - 1) - 1;
  localparam int NORMAL_FRAC_BITS_DEF = 14;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t ax, ay, az;
    coord_t bx, by, bz;
    coord_t cx, cy, cz;
  } tri_t;

  typedef struct packed {
    logic                  vld;
    logic                  drop;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } cross_t;

  typedef struct packed {
    logic                vld;
    logic                drop;
    logic [2:0]          neg;
    logic [2:0][S_W-1:0] s;
  } shift_t;

  typedef struct packed {
    logic       vld;
    logic       drop;
    logic       zero;
    logic [2:0] neg;
  } rnd_ctl_t;

endpackage

@@ src/triangle_normal_degenerate_filter_unit.sv @@
// Triangle face normal unit with degenerate-triangle filter (top level).
`timescale 1ns / 1ps
`include "triangle_normal_degenerate_filter_unit_defines.svh"
// Takes one triangle per clock while the pipeline is not held and returns one result per
// triangle, in order. Three stages form the edges and the cross product, three filter on
// squared area and normalize the cross product, two form the norm, one stage per result
// bit of the rounded normal, and an output register. The
// whole pipeline holds while the output register is full and not taken, so in_ready is low
// only in that case. min_area_sq is taken at any time through cfg_valid/cfg_ready and must
// be written only while the pipeline is empty. Dropped triangles report zero normals.
module triangle_normal_degenerate_filter_unit #(
  parameter int NORMAL_FRAC_BITS = tndf_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tndf_pkg::coord_t                  in_vertex_a_x,
  input  tndf_pkg::coord_t                  in_vertex_a_y,
  input  tndf_pkg::coord_t                  in_vertex_a_z,
  input  tndf_pkg::coord_t                  in_vertex_b_x,
  input  tndf_pkg::coord_t                  in_vertex_b_y,
  input  tndf_pkg::coord_t                  in_vertex_b_z,
  input  tndf_pkg::coord_t                  in_vertex_c_x,
  input  tndf_pkg::coord_t                  in_vertex_c_y,
  input  tndf_pkg::coord_t                  in_vertex_c_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_dropped,
  output logic signed [tndf_pkg::OUT_W-1:0] out_normal_x,
  output logic signed [tndf_pkg::OUT_W-1:0] out_normal_y,
  output logic signed [tndf_pkg::OUT_W-1:0] out_normal_z,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tndf_pkg::AREA_W-1:0]       cfg_min_area_sq
);
  import tndf_pkg::*;

  logic                         en;
  logic [AREA_W-1:0]            min_area_sq_r;
  tri_t                         tri_in;
  cross_t                       cross_s;
  shift_t                       shift_s;
  rnd_ctl_t                     rnd_ctl;
  logic [2:0][NORMAL_FRAC_BITS:0] rnd_m;

  logic                         out_vld_r, out_drop_r;
  logic [2:0][OUT_W-1:0]        out_n_r;
  logic [2:0][OUT_W-1:0]        n_nxt;
  logic [31:0]                  mag32;

  // Advance the whole pipeline unless the output item is stuck
  assign en        = !out_vld_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_area_sq_r <= '0;
    end else if (cfg_valid) begin
      min_area_sq_r <= cfg_min_area_sq;
    end
  end

  assign tri_in = '{ax: in_vertex_a_x, ay: in_vertex_a_y, az: in_vertex_a_z,
                    bx: in_vertex_b_x, by: in_vertex_b_y, bz: in_vertex_b_z,
                    cx: in_vertex_c_x, cy: in_vertex_c_y, cz: in_vertex_c_z};

  tndf_cross u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .tri_i   (tri_in),
    .cross_o (cross_s)
  );

  tndf_area u_area (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .min_area_sq (min_area_sq_r),
    .cross_i     (cross_s),
    .shift_o     (shift_s)
  );

  tndf_round #(
    .FRAC (NORMAL_FRAC_BITS)
  ) u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .shift_i (shift_s),
    .ctl_o   (rnd_ctl),
    .m_o     (rnd_m)
  );

  // Apply sign, clamp to the output range, zero dropped and degenerate results
  always_comb begin
    mag32 = '0;
    for (int c = 0; c < 3; c++) begin
      mag32 = 32'(rnd_m[c]);
      if (rnd_ctl.drop || rnd_ctl.zero) begin
        n_nxt[c] = '0;
      end else if (!rnd_ctl.neg[c]) begin
        n_nxt[c] = (mag32 > 32'(OUT_MAX)) ? OUT_W'(OUT_MAX) : mag32[OUT_W-1:0];
      end else begin
        n_nxt[c] = (mag32 > 32'(OUT_MAX + 1)) ? OUT_W'(OUT_MAX + 1)
                                               : OUT_W'(0) - mag32[OUT_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= rnd_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_drop_r <= rnd_ctl.drop;
      out_n_r    <= n_nxt;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_dropped  = out_drop_r;
  assign out_normal_x = out_n_r[0];
  assign out_normal_y = out_n_r[1];
  assign out_normal_z = out_n_r[2];

  `TNDF_ASSERT_IMPL(a_drop_zero, clk, rst_n, out_valid && out_dropped, out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0, "dropped item carries a nonzero normal")
  `TNDF_ASSERT_IMPL(a_stall_holds, clk, rst_n, out_valid && !out_ready, !in_ready, "input taken while output is stalled")
  `TNDF_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_valid && cfg_ready, min_area_sq_r == $past(cfg_min_area_sq), "threshold write lost")

endmodule

@@ src/tndf_cross.sv @@
// Edge vectors, coincident-vertex check and cross product (three stages).
`timescale 1ns / 1ps
module tndf_cross (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  tndf_pkg::tri_t  tri_i,
  output tndf_pkg::cross_t cross_o
);
  import tndf_pkg::*;

  logic                      s1_vld_r, s1_eq_r;
  logic signed [DIFF_W-1:0]  s1_u_r [3];
  logic signed [DIFF_W-1:0]  s1_v_r [3];
  logic                      eq_nxt;

  logic                      s2_vld_r, s2_eq_r;
  logic signed [PROD_W-1:0]  s2_p_r [6];

  logic                      s3_vld_r, s3_eq_r;
  logic [2:0]                s3_neg_r;
  logic [2:0][MAG_W-1:0]     s3_mag_r;
  logic signed [PROD_W-1:0]  w_nxt [3];
  logic signed [PROD_W-1:0]  wabs  [3];

  // Drop when any two vertices coincide
  assign eq_nxt = (tri_i.ax == tri_i.bx && tri_i.ay == tri_i.by && tri_i.az == tri_i.bz) ||
                  (tri_i.ax == tri_i.cx && tri_i.ay == tri_i.cy && tri_i.az == tri_i.cz) ||
                  (tri_i.bx == tri_i.cx && tri_i.by == tri_i.cy && tri_i.bz == tri_i.cz);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // Stage 1: edges u = b - a, v = c - a
  always_ff @(posedge clk) begin
    if (en) begin
      s1_eq_r   <= eq_nxt;
      s1_u_r[0] <= DIFF_W'(tri_i.bx) - DIFF_W'(tri_i.ax);
      s1_u_r[1] <= DIFF_W'(tri_i.by) - DIFF_W'(tri_i.ay);
      s1_u_r[2] <= DIFF_W'(tri_i.bz) - DIFF_W'(tri_i.az);
      s1_v_r[0] <= DIFF_W'(tri_i.cx) - DIFF_W'(tri_i.ax);
      s1_v_r[1] <= DIFF_W'(tri_i.cy) - DIFF_W'(tri_i.ay);
      s1_v_r[2] <= DIFF_W'(tri_i.cz) - DIFF_W'(tri_i.az);
    end
  end

  // Stage 2: six signed products
  always_ff @(posedge clk) begin
    if (en) begin
      s2_eq_r   <= s1_eq_r;
      s2_p_r[0] <= s1_u_r[1] * s1_v_r[2];
      s2_p_r[1] <= s1_u_r[2] * s1_v_r[1];
      s2_p_r[2] <= s1_u_r[2] * s1_v_r[0];
      s2_p_r[3] <= s1_u_r[0] * s1_v_r[2];
      s2_p_r[4] <= s1_u_r[0] * s1_v_r[1];
      s2_p_r[5] <= s1_u_r[1] * s1_v_r[0];
    end
  end

  // Stage 3: cross components as sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_nxt[i] = s2_p_r[2*i] - s2_p_r[2*i+1];
      wabs[i]  = w_nxt[i][PROD_W-1] ? -w_nxt[i] : w_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_eq_r <= s2_eq_r;
      for (int i = 0; i < 3; i++) begin
        s3_neg_r[i] <= w_nxt[i][PROD_W-1];
        s3_mag_r[i] <= wabs[i][MAG_W-1:0];
      end
    end
  end

  assign cross_o.vld  = s3_vld_r;
  assign cross_o.drop = s3_eq_r;
  assign cross_o.neg  = s3_neg_r;
  assign cross_o.mag  = s3_mag_r;

endmodule

@@ src/tndf_area.sv @@
// Squared-area filter and normalizing shift of the cross product (three stages).
`timescale 1ns / 1ps
module tndf_area (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [tndf_pkg::AREA_W-1:0] min_area_sq,
  input  tndf_pkg::cross_t           cross_i,
  output tndf_pkg::shift_t           shift_o
);
  import tndf_pkg::*;

  logic                           a4_vld_r, a4_drop_r;
  logic [2:0]                     a4_neg_r, a4_sat_r;
  logic [2:0][MAG_W-1:0]          a4_mag_r;
  logic [2:0][2*SPLIT_HI-1:0]     a4_hh_r;
  logic [2:0][SAT_BITS-1:0]       a4_hl_r;
  logic [2:0][2*SPLIT_LO-1:0]     a4_ll_r;
  logic [MAG_W-1:0]               a4_mx_r;
  logic [MAG_W-1:0]               mx01, mx_nxt;

  logic                           a5_vld_r, a5_drop_r;
  logic [2:0]                     a5_neg_r;
  logic [2:0][MAG_W-1:0]          a5_mag_r;
  logic [K_W-1:0]                 a5_k_r;
  logic [ACC_W-1:0]               acc;
  logic [AREA_W-1:0]              area;
  logic                           sat;
  logic [K_W-1:0]                 pos, k_nxt;

  logic                           a6_vld_r, a6_drop_r;
  logic [2:0]                     a6_neg_r;
  logic [2:0][S_W-1:0]            a6_s_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a4_vld_r <= 1'b0;
      a5_vld_r <= 1'b0;
      a6_vld_r <= 1'b0;
    end else if (en) begin
      a4_vld_r <= cross_i.vld;
      a5_vld_r <= a4_vld_r;
      a6_vld_r <= a5_vld_r;
    end
  end

  // Stage 4: split squares into partial products, find largest magnitude
  assign mx01   = (cross_i.mag[0] >= cross_i.mag[1]) ? cross_i.mag[0] : cross_i.mag[1];
  assign mx_nxt = (mx01 >= cross_i.mag[2]) ? mx01 : cross_i.mag[2];

  always_ff @(posedge clk) begin
    if (en) begin
      a4_drop_r <= cross_i.drop;
      a4_neg_r  <= cross_i.neg;
      a4_mag_r  <= cross_i.mag;
      a4_mx_r   <= mx_nxt;
      for (int i = 0; i < 3; i++) begin
        a4_sat_r[i] <= |cross_i.mag[i][MAG_W-1:SAT_BITS];
        a4_hh_r[i]  <= cross_i.mag[i][SAT_BITS-1:SPLIT_LO] * cross_i.mag[i][SAT_BITS-1:SPLIT_LO];
        a4_hl_r[i]  <= cross_i.mag[i][SAT_BITS-1:SPLIT_LO] * cross_i.mag[i][SPLIT_LO-1:0];
        a4_ll_r[i]  <= cross_i.mag[i][SPLIT_LO-1:0] * cross_i.mag[i][SPLIT_LO-1:0];
      end
    end
  end

  // Stage 5: sum of squares, saturate, compare against threshold
  always_comb begin
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      acc = acc + (ACC_W'(a4_hh_r[i]) << (2 * SPLIT_LO))
                + (ACC_W'(a4_hl_r[i]) << (SPLIT_LO + 1))
                + ACC_W'(a4_ll_r[i]);
    end
    sat  = (|a4_sat_r) || (|acc[ACC_W-1:AREA_SHIFT+AREA_W]);
    area = sat ? {AREA_W{1'b1}} : acc[AREA_SHIFT+AREA_W-1:AREA_SHIFT];
  end

  // Leading one of the largest magnitude sets the shift
  always_comb begin
    pos = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (a4_mx_r[i]) pos = K_W'(i);
    end
    k_nxt = (pos >= K_W'(S_W)) ? pos - K_W'(S_W - 1) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a5_drop_r <= a4_drop_r || (area < min_area_sq);
      a5_neg_r  <= a4_neg_r;
      a5_mag_r  <= a4_mag_r;
      a5_k_r    <= k_nxt;
    end
  end

  // Stage 6: shift magnitudes below 2^31
  always_ff @(posedge clk) begin
    if (en) begin
      a6_drop_r <= a5_drop_r;
      a6_neg_r  <= a5_neg_r;
      for (int i = 0; i < 3; i++) begin
        a6_s_r[i] <= S_W'(a5_mag_r[i] >> a5_k_r);
      end
    end
  end

  assign shift_o.vld  = a6_vld_r;
  assign shift_o.drop = a6_drop_r;
  assign shift_o.neg  = a6_neg_r;
  assign shift_o.s    = a6_s_r;

endmodule

@@ src/tndf_round.sv @@
// Rounded unit normal: squares, norm and one result bit per stage.
`timescale 1ns / 1ps
module tndf_round #(
  parameter int FRAC = tndf_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  tndf_pkg::shift_t         shift_i,
  output tndf_pkg::rnd_ctl_t       ctl_o,
  output logic [2:0][FRAC:0]       m_o
);
  import tndf_pkg::*;

  localparam int NST = FRAC + 2;
  localparam int PW  = 2 * FRAC + 70;

  // Stage A: squares
  logic                  a_vld_r, a_drop_r;
  logic [2:0]            a_neg_r;
  logic [2:0][SQ_W-1:0]  a_sq_r;
  logic [SUM_W-1:0]      sum_nxt;

  // Stage B and bit stages
  rnd_ctl_t              ctl_r   [NST];
  logic [2:0][SQ_W-1:0]  sq_r    [NST];
  logic [SUM_W-1:0]      sum_r   [NST];
  logic signed [PW-1:0]  p_r     [NST][3];
  logic signed [PW-1:0]  q_r     [NST][3];
  logic [FRAC:0]         m_r     [NST][3];

  logic signed [PW-1:0]  p_nxt   [NST][3];
  logic signed [PW-1:0]  q_nxt   [NST][3];
  logic [FRAC:0]         m_nxt   [NST][3];
  logic signed [PW-1:0]  pc, qc, rr, sx;
  logic                  ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= shift_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_drop_r <= shift_i.drop;
      a_neg_r  <= shift_i.neg;
      for (int i = 0; i < 3; i++) begin
        a_sq_r[i] <= shift_i.s[i] * shift_i.s[i];
      end
    end
  end

  assign sum_nxt = SUM_W'(a_sq_r[0]) + SUM_W'(a_sq_r[1]) + SUM_W'(a_sq_r[2]);

  // Try one result bit per stage: (2t-1)^2 * S <= (2 s 2^F)^2,
  // with P = (2m-1)^2 S and Q = (2m-1) S kept up to date by shifts and adds
  always_comb begin
    pc = '0;
    qc = '0;
    rr = '0;
    sx = '0;
    ok = 1'b0;
    for (int j = 0; j < NST; j++) begin
      for (int c = 0; c < 3; c++) begin
        p_nxt[j][c] = p_r[j][c];
        q_nxt[j][c] = q_r[j][c];
        m_nxt[j][c] = m_r[j][c];
      end
    end
    for (int j = 0; j < NST - 1; j++) begin
      sx = $signed(PW'(sum_r[j]));
      for (int c = 0; c < 3; c++) begin
        pc = p_r[j][c] + (q_r[j][c] <<< (FRAC - j + 2)) + (sx <<< (2 * (FRAC - j) + 2));
        qc = q_r[j][c] + (sx <<< (FRAC - j + 1));
        rr = $signed(PW'(sq_r[j][c])) <<< (2 * FRAC + 2);
        ok = (pc <= rr) && ((j == 0) || !m_r[j][c][FRAC]);
        p_nxt[j][c] = ok ? pc : p_r[j][c];
        q_nxt[j][c] = ok ? qc : q_r[j][c];
        m_nxt[j][c] = ok ? (m_r[j][c] | ((FRAC+1)'(1) << (FRAC - j))) : m_r[j][c];
      end
    end
  end

  // Advance stage B and the bit stages; valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NST; j++) ctl_r[j].vld <= 1'b0;
    end else if (en) begin
      ctl_r[0].vld <= a_vld_r;
      for (int j = 1; j < NST; j++) ctl_r[j].vld <= ctl_r[j-1].vld;
    end
    if (en) begin
      // Stage B: norm squared, start with m = 0
      ctl_r[0].drop <= a_drop_r;
      ctl_r[0].zero <= (sum_nxt == '0);
      ctl_r[0].neg  <= a_neg_r;
      sq_r[0]       <= a_sq_r;
      sum_r[0]      <= sum_nxt;
      for (int c = 0; c < 3; c++) begin
        p_r[0][c] <= $signed(PW'(sum_nxt));
        q_r[0][c] <= -$signed(PW'(sum_nxt));
        m_r[0][c] <= '0;
      end
      // Bit stages
      for (int j = 1; j < NST; j++) begin
        ctl_r[j].drop <= ctl_r[j-1].drop;
        ctl_r[j].zero <= ctl_r[j-1].zero;
        ctl_r[j].neg  <= ctl_r[j-1].neg;
        sq_r[j]       <= sq_r[j-1];
        sum_r[j]      <= sum_r[j-1];
        for (int c = 0; c < 3; c++) begin
          p_r[j][c] <= p_nxt[j-1][c];
          q_r[j][c] <= q_nxt[j-1][c];
          m_r[j][c] <= m_nxt[j-1][c];
        end
      end
    end
  end

  assign ctl_o = ctl_r[NST-1];
  always_comb begin
    for (int c = 0; c < 3; c++) m_o[c] = m_r[NST-1][c];
  end

endmodule
